[rtl/double_ended_priority_queue_defines.svh]
// Assertion helpers used by the checker file.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define DEPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("depq check failed");

// next-cycle implication
`define DEPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("depq check failed");

`endif

[rtl/depq_pkg.sv]
package depq_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 1024;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned ENTRY_W = 11;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT  = 2'd0,
      KIND_DEL_MAX = 2'd1,
      KIND_DEL_MIN = 2'd2,
      KIND_CLEAR   = 2'd3
   } kind_type;

   typedef struct packed {
      logic load_req;
      logic set_drop;
      logic set_pos;
      logic rd_pos_m1;
      logic wr_shift;
      logic wr_key;
      logic del_max;
      logic del_min;
      logic clear;
      logic rd_max;
      logic cap_max;
      logic cap_min;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     full;
      logic     pos_zero;
      logic     greater;
      logic     rsp_free;
   } status_type;

endpackage

[rtl/depq_datapath.sv]
module depq_datapath #(
   parameter int unsigned CAPACITY = depq_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  depq_pkg::cmd_type                   cmd,
   output depq_pkg::status_type                status,
   input  logic [depq_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [depq_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [depq_pkg::VALUE_W-1:0] rsp_max_value,
   output logic signed [depq_pkg::VALUE_W-1:0] rsp_min_value,
   output logic                                rsp_is_empty,
   output logic [depq_pkg::ENTRY_W-1:0]        rsp_entry_count,
   output logic                                rsp_dropped
);
   localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic [depq_pkg::VALUE_W-1:0] mem [CAPACITY];

   logic [depq_pkg::VALUE_W-1:0] rd_data_ff;
   logic signed [depq_pkg::VALUE_W-1:0] key_ff, max_ff, min_ff;
   depq_pkg::kind_type kind_ff;
   logic [CW-1:0] count_ff, count_in, pos_ff, pos_in;
   logic [IW-1:0] head_ff, head_in;
   logic dropped_ff, dropped_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [depq_pkg::VALUE_W-1:0] rsp_max_ff, rsp_min_ff;
   logic rsp_empty_ff, rsp_dropped_ff;
   logic [depq_pkg::ENTRY_W-1:0] rsp_count_ff;

   logic [IW-1:0] rd_addr, wr_addr;
   logic [depq_pkg::VALUE_W-1:0] wr_data;
   logic wr_en;

   // logical position -> physical slot of the circular store
   function automatic logic [IW-1:0] phys(input logic [IW-1:0] head, input logic [CW-1:0] lpos);
      logic [IW:0] sum;
      sum = {1'b0, head} + (IW+1)'(lpos);
      if (sum >= (IW+1)'(CAPACITY)) begin
         sum = sum - (IW+1)'(CAPACITY);
      end
      return sum[IW-1:0];
   endfunction

   always_comb begin
      rd_addr = phys(head_ff, '0);
      if (cmd.rd_pos_m1) begin
         rd_addr = phys(head_ff, pos_ff - CW'(1));
      end else if (cmd.rd_max) begin
         rd_addr = phys(head_ff, count_ff - CW'(1));
      end
      wr_en   = cmd.wr_shift | cmd.wr_key;
      wr_addr = phys(head_ff, pos_ff);
      wr_data = cmd.wr_shift ? rd_data_ff : key_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      count_in   = count_ff;
      pos_in     = pos_ff;
      head_in    = head_ff;
      dropped_in = dropped_ff;
      if (cmd.load_req) dropped_in = 1'b0;
      if (cmd.set_drop) dropped_in = 1'b1;
      if (cmd.set_pos) pos_in = count_ff;
      if (cmd.wr_shift) pos_in = pos_ff - CW'(1);
      if (cmd.wr_key) count_in = count_ff + CW'(1);
      if (cmd.del_max && count_ff != '0) count_in = count_ff - CW'(1);
      if (cmd.del_min && count_ff != '0) begin
         count_in = count_ff - CW'(1);
         head_in  = phys(head_ff, CW'(1));
      end
      if (cmd.clear) count_in = '0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         head_ff      <= '0;
         pos_ff       <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         head_ff      <= head_in;
         pos_ff       <= pos_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         key_ff  <= req_value;
         kind_ff <= depq_pkg::kind_type'(req_kind);
      end
      if (cmd.cap_max) max_ff <= rd_data_ff;
      if (cmd.cap_min) min_ff <= rd_data_ff;
      if (cmd.load_rsp) begin
         rsp_empty_ff   <= (count_ff == '0);
         rsp_max_ff     <= (count_ff == '0) ? '0 : max_ff;
         rsp_min_ff     <= (count_ff == '0) ? '0 : min_ff;
         rsp_count_ff   <= depq_pkg::ENTRY_W'(count_ff);
         rsp_dropped_ff <= dropped_ff;
      end
   end

   always_comb begin
      status.kind       = kind_ff;
      status.full       = (count_ff >= CW'(CAPACITY));
      status.pos_zero   = (pos_ff == '0);
      status.greater    = ($signed(rd_data_ff) > key_ff);
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_max_value   = rsp_max_ff;
   assign rsp_min_value   = rsp_min_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_dropped     = rsp_dropped_ff;

endmodule

[rtl/depq_control.sv]
module depq_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  depq_pkg::status_type status,
   output depq_pkg::cmd_type    cmd
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_INS_CHK, ST_INS_CMP, ST_RD_MAX, ST_RD_MIN, ST_CAP_MIN, ST_RESULT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_RD_MAX;
            case (status.kind)
               depq_pkg::KIND_INSERT: begin
                  if (status.full) begin
                     cmd.set_drop = 1'b1;
                  end else begin
                     cmd.set_pos = 1'b1;
                     state_in    = ST_INS_CHK;
                  end
               end
               depq_pkg::KIND_DEL_MAX: cmd.del_max = 1'b1;
               depq_pkg::KIND_DEL_MIN: cmd.del_min = 1'b1;
               default:                cmd.clear   = 1'b1;
            endcase
         end
         ST_INS_CHK: begin
            if (status.pos_zero) begin
               cmd.wr_key = 1'b1;
               state_in   = ST_RD_MAX;
            end else begin
               cmd.rd_pos_m1 = 1'b1;
               state_in      = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            // larger neighbor moves up one slot; otherwise the key lands here
            if (status.greater) begin
               cmd.wr_shift = 1'b1;
               state_in     = ST_INS_CHK;
            end else begin
               cmd.wr_key = 1'b1;
               state_in   = ST_RD_MAX;
            end
         end
         ST_RD_MAX: begin
            cmd.rd_max = 1'b1;
            state_in   = ST_RD_MIN;
         end
         ST_RD_MIN: begin
            // read address defaults to the min slot
            cmd.cap_max = 1'b1;
            state_in    = ST_CAP_MIN;
         end
         ST_CAP_MIN: begin
            cmd.cap_min = 1'b1;
            state_in    = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

[rtl/double_ended_priority_queue.sv]
// Double-ended priority queue of signed 32-bit values, up to CAPACITY entries kept sorted
// in a circular memory with one read and one write port. One transaction in (insert,
// delete max, delete min, clear) gives one transaction out with max, min, empty flag,
// count and drop flag. Each request is decoded, then max and min are read back and the
// result is loaded into the output register once that register is free; an insert first
// moves each stored value larger than the new one up one slot through the memory's one
// read and one write port, and then writes the new value. The next request is accepted
// in the cycle after the result is loaded into the output register.
// Delete min only advances the head pointer. No clearing pass is needed after reset.
module double_ended_priority_queue #(
   parameter int unsigned CAPACITY = depq_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [depq_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [depq_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [depq_pkg::VALUE_W-1:0] rsp_max_value,
   output logic signed [depq_pkg::VALUE_W-1:0] rsp_min_value,
   output logic                                rsp_is_empty,
   output logic [depq_pkg::ENTRY_W-1:0]        rsp_entry_count,
   output logic                                rsp_dropped
);
   depq_pkg::cmd_type    cmd;
   depq_pkg::status_type status;

   depq_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   depq_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_max_value   (rsp_max_value),
      .rsp_min_value   (rsp_min_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry_count (rsp_entry_count),
      .rsp_dropped     (rsp_dropped)
   );

endmodule

[rtl/depq_checker.sv]
`include "double_ended_priority_queue_defines.svh"

module depq_assertions (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [depq_pkg::VALUE_W-1:0] rsp_max_value,
   input logic signed [depq_pkg::VALUE_W-1:0] rsp_min_value,
   input logic                                rsp_is_empty,
   input logic [depq_pkg::ENTRY_W-1:0]        rsp_entry_count,
   input logic                                rsp_dropped
);
   logic empty_ok, order_ok, stalled;

   assign empty_ok = (rsp_entry_count == '0) && (rsp_max_value == '0) && (rsp_min_value == '0);
   assign order_ok = (rsp_min_value <= rsp_max_value);
   assign stalled  = rsp_valid && rsp_stall;

   `DEPQ_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && rsp_is_empty, empty_ok)
   `DEPQ_ASSERT_NOW(a_min_le_max, clock, reset, rsp_valid && !rsp_is_empty, order_ok)
   `DEPQ_ASSERT_NOW(a_drop_full, clock, reset, rsp_valid && rsp_dropped, !rsp_is_empty)
   `DEPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid && $stable(rsp_max_value))

endmodule

bind double_ended_priority_queue depq_assertions u_depq_assertions (.*);
